FILE: hdl/tlik_pkg.sv
package tlik_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELBOW_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN     = 3'd5;

  localparam logic [14:0] FIRST_LENGTH_RST  = 15'd4915;
  localparam logic [14:0] SECOND_LENGTH_RST = 15'd5079;
  localparam logic [15:0] STEP_GAIN_RST     = 16'd13107;

  // phase codes; the unused fourth code behaves as idle
  typedef enum logic [1:0] {
    CMD_TRACK = 2'd0,
    CMD_FINAL = 2'd1,
    CMD_IDLE  = 2'd2
  } cmd_t;

  typedef logic signed [17:0] ang_t;

  localparam ang_t        PI_Q12      = 18'sd12868;
  localparam logic signed [31:0] PI_HALF_Q24 = 32'sd26353589;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] shoulder_command;
    logic signed [15:0] elbow_command;
    logic               motors_idle;
    logic               out_of_reach;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               elbow_right;
    logic [14:0]        first_link_length;
    logic [14:0]        second_link_length;
  } ik_cfg_t;

  typedef struct packed {
    ang_t t1;
    ang_t t2;
    logic bad;
  } ik_sol_t;

  // atan(2^-i) in radians * 2^24
  function automatic logic [23:0] atan_q24(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047214;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/two_link_ik_joint_servo_core.sv
// Joint servo for a planar two-link arm. Each word on in_word (phase, measured
// shoulder and elbow angles) is taken at a clock edge where start is high and
// busy is low, and exactly one result word appears on out_word when it leaves the
// pipeline described below, marked by a one-cycle out_valid strobe. The
// receiver cannot stall: results must be captured in the strobe cycle.
// While the arm solution is current, a new word is taken every cycle through
// a three-stage pipeline (error, gain multiply, round/select/saturate). The
// inverse kinematics depend only on configuration, so they are solved once by
// a shared sequential unit (iterative square root, restoring divider, one
// CORDIC rotation per cycle) after reset and after every cfg_we write; busy
// stays high during that solve, which ends early when the target is out of
// reach. Write configuration only with no results pending.
module two_link_ik_joint_servo_core import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic signed [15:0] target_x_r, target_y_r;
  logic               elbow_right_r;
  logic [14:0]        first_len_r, second_len_r;
  logic [15:0]        step_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r    <= '0;
      target_y_r    <= '0;
      elbow_right_r <= 1'b0;
      first_len_r   <= FIRST_LENGTH_RST;
      second_len_r  <= SECOND_LENGTH_RST;
      step_gain_r   <= STEP_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:      target_x_r    <= cfg_data;
        REG_TARGET_Y:      target_y_r    <= cfg_data;
        REG_ELBOW_RIGHT:   elbow_right_r <= cfg_data[0];
        REG_FIRST_LENGTH:  first_len_r   <= cfg_data[14:0];
        REG_SECOND_LENGTH: second_len_r  <= cfg_data[14:0];
        REG_STEP_GAIN:     step_gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  ik_cfg_t ik_cfg;
  ik_sol_t sol;
  logic    solver_busy;

  assign ik_cfg.target_x           = target_x_r;
  assign ik_cfg.target_y           = target_y_r;
  assign ik_cfg.elbow_right        = elbow_right_r;
  assign ik_cfg.first_link_length  = first_len_r;
  assign ik_cfg.second_link_length = second_len_r;

  // re-solve on every write; the solution holds steady while words flow
  tlik_solver #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_solver (
    .clk    (clk),
    .rst_n  (rst_n),
    .restart(cfg_we),
    .cfg    (ik_cfg),
    .sol    (sol),
    .busy   (solver_busy)
  );

  assign busy = solver_busy;

  logic accept;
  assign accept = start && !solver_busy;

  // stage 1: joint errors
  logic               v1_r;
  logic [1:0]         cmd1_r;
  logic signed [15:0] m1a_r, m1b_r;
  logic signed [18:0] d1a_r, d1b_r;

  // stage 2: gain products
  logic               v2_r;
  logic [1:0]         cmd2_r;
  logic signed [15:0] m2a_r, m2b_r;
  logic signed [35:0] p2a_r, p2b_r;

  // stage 3: output register
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  logic signed [16:0] gain_s;
  assign gain_s = $signed({1'b0, step_gain_r});

  always_ff @(posedge clk) begin
    cmd1_r <= in_word.cmd;
    m1a_r  <= in_word.shoulder_angle;
    m1b_r  <= in_word.elbow_angle;
    d1a_r  <= 19'(sol.t1) - 19'(in_word.shoulder_angle);
    d1b_r  <= 19'(sol.t2) - 19'(in_word.elbow_angle);

    cmd2_r <= cmd1_r;
    m2a_r  <= m1a_r;
    m2b_r  <= m1b_r;
    p2a_r  <= gain_s * d1a_r;
    p2b_r  <= gain_s * d1b_r;
  end

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] s;
    if (v > 21'sd32767)       s = 16'sd32767;
    else if (v < -21'sd32768) s = -16'sd32768;
    else                      s = v[15:0];
    return s;
  endfunction

  // round the step to nearest, half up, then pick by phase
  logic signed [35:0] stepa_w, stepb_w;
  logic signed [20:0] tracka_w, trackb_w;
  out_word_t          res_w;

  assign stepa_w  = (p2a_r + 36'sd32768) >>> 16;
  assign stepb_w  = (p2b_r + 36'sd32768) >>> 16;
  assign tracka_w = 21'(m2a_r) + stepa_w[20:0];
  assign trackb_w = 21'(m2b_r) + stepb_w[20:0];

  always_comb begin
    res_w.motors_idle  = 1'b0;
    res_w.out_of_reach = sol.bad;
    if (cmd2_r >= CMD_IDLE) begin
      // idle and the unused code: release motors
      res_w.shoulder_command = '0;
      res_w.elbow_command    = '0;
      res_w.motors_idle      = 1'b1;
    end else if (sol.bad) begin
      // hold the measured angles
      res_w.shoulder_command = m2a_r;
      res_w.elbow_command    = m2b_r;
    end else if (cmd2_r == CMD_FINAL) begin
      res_w.shoulder_command = sat16(21'(sol.t1));
      res_w.elbow_command    = sat16(21'(sol.t2));
    end else begin
      res_w.shoulder_command = sat16(tracka_w);
      res_w.elbow_command    = sat16(trackb_w);
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= res_w;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: hdl/tlik_solver.sv
module tlik_solver import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    restart,
  input  ik_cfg_t cfg,
  output ik_sol_t sol,
  output logic    busy
);

  localparam int CNT_W = $clog2(CORDIC_STAGES);
  localparam logic [CNT_W-1:0] LAST_STAGE = CNT_W'(CORDIC_STAGES - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MX, S_MY, S_ML1, S_ML2, S_MLL, S_CHK, S_SQRT, S_SQDONE, S_DENB,
    S_DIVINIT, S_DIV, S_CSQ, S_CORINIT, S_COR, S_CORDONE, S_FIN
  } state_t;

  typedef enum logic [1:0] {W_R, W_ALPHA, W_BETA, W_PHI} which_t;

  state_t state_r;
  which_t which_r;

  logic [31:0]        r2_r, xx_r, l1sq_r, l2sq_r, den_a_r;
  logic signed [33:0] num_a_r, num_b_r;
  logic [33:0]        den_b_r;
  logic [16:0]        r_r;
  logic               bad_r;

  logic [33:0] sq_v_r, sq_res_r, sq_bit_r;

  logic [33:0] dv_rem_r, dv_den_r;
  logic [13:0] dv_q_r;
  logic [3:0]  dv_cnt_r;
  logic        dv_neg_r;
  logic signed [15:0] c_r;

  logic signed [33:0] co_x_r, co_y_r;
  logic signed [31:0] co_z_r;
  logic [CNT_W-1:0]   co_cnt_r;
  logic               co_zero_r;

  ang_t alpha_r, beta_r, phi_r, t1_r, t2_r;

  // products, one per state
  logic signed [31:0] txsq_w, tysq_w, csq_w;
  logic [29:0]        l1sq_w, l2sq_w, l12_w;
  logic [31:0]        l1r_w;

  assign txsq_w = cfg.target_x * cfg.target_x;
  assign tysq_w = cfg.target_y * cfg.target_y;
  assign csq_w  = c_r * c_r;
  assign l1sq_w = cfg.first_link_length * cfg.first_link_length;
  assign l2sq_w = cfg.second_link_length * cfg.second_link_length;
  assign l12_w  = cfg.first_link_length * cfg.second_link_length;
  assign l1r_w  = cfg.first_link_length * r_r;

  logic signed [33:0] num_a_w, num_b_w, den_a_s;
  logic               bad_w;

  assign num_a_w = $signed({2'b00, l1sq_r}) + $signed({2'b00, l2sq_r})
                 - $signed({2'b00, r2_r});
  assign num_b_w = $signed({2'b00, l1sq_r}) - $signed({2'b00, l2sq_r})
                 + $signed({2'b00, r2_r});
  assign den_a_s = $signed({2'b00, den_a_r});
  assign bad_w = (r2_r == 32'd0) || (cfg.first_link_length == 15'd0) ||
                 (cfg.second_link_length == 15'd0) ||
                 (num_a_w > den_a_s) || (-num_a_w > den_a_s);

  // square root step
  logic [33:0] sq_try_w;
  assign sq_try_w = sq_res_r + sq_bit_r;

  // divider setup and step
  logic signed [33:0] dv_num_w;
  logic [33:0]        dv_mag_w, dv_den_w, dv_rem2_w;
  logic               dv_ge_w;
  logic [13:0]        dv_q_nxt;

  assign dv_num_w  = (which_r == W_ALPHA) ? num_a_r : num_b_r;
  assign dv_den_w  = (which_r == W_ALPHA) ? {2'b00, den_a_r} : den_b_r;
  assign dv_mag_w  = dv_num_w[33] ? 34'(-dv_num_w) : 34'(dv_num_w);
  assign dv_rem2_w = {dv_rem_r[32:0], 1'b0};
  assign dv_ge_w   = dv_rem2_w >= dv_den_r;
  assign dv_q_nxt  = {dv_q_r[12:0], dv_ge_w};

  // CORDIC setup and step
  logic signed [17:0] co_yin_w, co_xin_w;
  logic signed [33:0] co_xs_w, co_ys_w, co_dx_w, co_dy_w;
  logic signed [31:0] co_atan_w, co_round_w;

  assign co_yin_w = (which_r == W_PHI) ? 18'(cfg.target_y) : $signed({1'b0, sq_res_r[16:0]});
  assign co_xin_w = (which_r == W_PHI) ? 18'(cfg.target_x) : 18'(c_r);
  assign co_xs_w  = 34'(co_xin_w) <<< 14;
  assign co_ys_w  = 34'(co_yin_w) <<< 14;
  assign co_dx_w  = co_x_r >>> co_cnt_r;
  assign co_dy_w  = co_y_r >>> co_cnt_r;
  assign co_atan_w  = $signed({8'd0, atan_q24(5'(co_cnt_r))});
  assign co_round_w = (co_z_r + 32'sd2048) >>> 12;

  function automatic ang_t wrap_pi(input ang_t a);
    ang_t b;
    b = a;
    if (b > PI_Q12) b = b - 18'(2 * PI_Q12);
    if (b < -PI_Q12) b = b + 18'(2 * PI_Q12);
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_MX;
      which_r <= W_R;
    end else if (restart) begin
      state_r <= S_MX;
      which_r <= W_R;
    end else begin
      unique case (state_r)
        S_IDLE: ;
        S_MX: begin
          xx_r    <= 32'(txsq_w);
          state_r <= S_MY;
        end
        S_MY: begin
          r2_r    <= xx_r + 32'(tysq_w);
          state_r <= S_ML1;
        end
        S_ML1: begin
          l1sq_r  <= {2'b00, l1sq_w};
          state_r <= S_ML2;
        end
        S_ML2: begin
          l2sq_r  <= {2'b00, l2sq_w};
          state_r <= S_MLL;
        end
        S_MLL: begin
          den_a_r <= {1'b0, l12_w, 1'b0};
          state_r <= S_CHK;
        end
        S_CHK: begin
          bad_r    <= bad_w;
          num_a_r  <= num_a_w;
          num_b_r  <= num_b_w;
          sq_v_r   <= {2'b00, r2_r};
          sq_res_r <= '0;
          sq_bit_r <= 34'd1 << 30;
          which_r  <= W_R;
          state_r  <= bad_w ? S_IDLE : S_SQRT;
        end
        S_SQRT: begin
          if (sq_v_r >= sq_try_w) begin
            sq_v_r   <= sq_v_r - sq_try_w;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r == 34'd1) state_r <= S_SQDONE;
        end
        S_SQDONE: begin
          if (which_r == W_R) begin
            r_r     <= sq_res_r[16:0];
            state_r <= S_DENB;
          end else begin
            state_r <= S_CORINIT;
          end
        end
        S_DENB: begin
          den_b_r <= {1'b0, l1r_w, 1'b0};
          which_r <= W_ALPHA;
          state_r <= S_DIVINIT;
        end
        S_DIVINIT: begin
          dv_neg_r <= dv_num_w[33];
          dv_rem_r <= dv_mag_w;
          dv_den_r <= dv_den_w;
          dv_q_r   <= '0;
          dv_cnt_r <= '0;
          if (dv_mag_w >= dv_den_w) begin
            // cosine at or beyond one: clamp
            c_r     <= dv_num_w[33] ? -16'sd16384 : 16'sd16384;
            state_r <= S_CSQ;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          dv_rem_r <= dv_ge_w ? dv_rem2_w - dv_den_r : dv_rem2_w;
          dv_q_r   <= dv_q_nxt;
          dv_cnt_r <= dv_cnt_r + 4'd1;
          if (dv_cnt_r == 4'd13) begin
            c_r     <= dv_neg_r ? -$signed({2'b00, dv_q_nxt}) : $signed({2'b00, dv_q_nxt});
            state_r <= S_CSQ;
          end
        end
        S_CSQ: begin
          sq_v_r   <= (34'd1 << 28) - 34'(csq_w);
          sq_res_r <= '0;
          sq_bit_r <= 34'd1 << 30;
          state_r  <= S_SQRT;
        end
        S_CORINIT: begin
          co_zero_r <= (co_xin_w == 18'sd0) && (co_yin_w == 18'sd0);
          co_cnt_r  <= '0;
          if (co_xs_w < 0) begin
            if (co_ys_w >= 0) begin
              co_x_r <= co_ys_w;
              co_y_r <= -co_xs_w;
              co_z_r <= PI_HALF_Q24;
            end else begin
              co_x_r <= -co_ys_w;
              co_y_r <= co_xs_w;
              co_z_r <= -PI_HALF_Q24;
            end
          end else begin
            co_x_r <= co_xs_w;
            co_y_r <= co_ys_w;
            co_z_r <= '0;
          end
          state_r <= S_COR;
        end
        S_COR: begin
          if (co_y_r > 0) begin
            co_x_r <= co_x_r + co_dy_w;
            co_y_r <= co_y_r - co_dx_w;
            co_z_r <= co_z_r + co_atan_w;
          end else begin
            co_x_r <= co_x_r - co_dy_w;
            co_y_r <= co_y_r + co_dx_w;
            co_z_r <= co_z_r - co_atan_w;
          end
          co_cnt_r <= co_cnt_r + 1'b1;
          if (co_cnt_r == LAST_STAGE) state_r <= S_CORDONE;
        end
        S_CORDONE: begin
          unique case (which_r)
            W_ALPHA: begin
              alpha_r <= co_zero_r ? '0 : co_round_w[17:0];
              which_r <= W_BETA;
              state_r <= S_DIVINIT;
            end
            W_BETA: begin
              beta_r  <= co_zero_r ? '0 : co_round_w[17:0];
              which_r <= W_PHI;
              state_r <= S_CORINIT;
            end
            W_PHI: begin
              phi_r   <= co_zero_r ? '0 : co_round_w[17:0];
              state_r <= S_FIN;
            end
            W_R: state_r <= S_FIN;
          endcase
        end
        S_FIN: begin
          if (cfg.elbow_right) begin
            t1_r <= wrap_pi(phi_r - beta_r);
            t2_r <= wrap_pi(PI_Q12 - alpha_r);
          end else begin
            t1_r <= wrap_pi(phi_r + beta_r);
            t2_r <= wrap_pi(PI_Q12 + alpha_r);
          end
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy    = (state_r != S_IDLE);
  assign sol.t1  = t1_r;
  assign sol.t2  = t2_r;
  assign sol.bad = bad_r;

endmodule

FILE: hdl/tlik_checker.sv
module tlik_checker import tlik_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_word_t              in_word,
  input logic                  out_valid,
  input out_word_t             out_word,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // every accepted word yields a result strobe at the pipeline output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted word produced no result");

  // a write triggers a new solve before the next word is taken
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("no solve after configuration write");

  // idle phase releases the motors with zero commands
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.motors_idle) |->
      (out_word.shoulder_command == 16'sd0 && out_word.elbow_command == 16'sd0))
    else $error("idle result carries nonzero command");

  // unreachable target holds the measured angles
  a_reach_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.motors_idle && out_word.out_of_reach) |->
      (out_word.shoulder_command == $past(in_word.shoulder_angle, 3) &&
       out_word.elbow_command == $past(in_word.elbow_angle, 3)))
    else $error("out-of-reach result does not hold measured angles");

endmodule

bind two_link_ik_joint_servo_core tlik_checker u_tlik_checker (.*);
